// ----- design/assert_macros.svh -----
// Assertion macros for the checker file kmm_checker.sv.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/kmm_pkg.sv -----
// Package for the key matrix to MIDI mapper: payload structs and codes.
// Used by the top level and its checker; depends on nothing.
`default_nettype none

package kmm_pkg;

  // Input beat
  typedef struct packed {
    logic [1:0]        func;
    logic [9:0]        key_code;
    logic [1:0]        key_value;
    logic [3:0]        entry_control;
    logic [1:0]        entry_kind;
    logic signed [7:0] entry_number;
  } kmm_in_t;

  // Result beat
  typedef struct packed {
    logic [2:0] msg_kind;
    logic [3:0] midi_channel;
    logic [6:0] data_first;
    logic [6:0] data_second;
    logic       last_of_run;
  } kmm_out_t;

  // Input function codes
  localparam logic [1:0] FuncKey      = 2'd0;
  localparam logic [1:0] FuncTick     = 2'd1;
  localparam logic [1:0] FuncMapWrite = 2'd2;

  // Key value codes
  localparam logic [1:0] KvRelease = 2'd0;
  localparam logic [1:0] KvRepeat  = 2'd2;

  // Map entry kinds
  localparam logic [1:0] KindNote  = 2'd1;
  localparam logic [1:0] KindPedal = 2'd2;

  // Control roles
  localparam logic [3:0] CtlNone     = 4'd0;
  localparam logic [3:0] CtlMode     = 4'd2;
  localparam logic [3:0] CtlOctDown  = 4'd3;
  localparam logic [3:0] CtlOctUp    = 4'd4;
  localparam logic [3:0] CtlChanDown = 4'd5;
  localparam logic [3:0] CtlChanUp   = 4'd6;
  localparam logic [3:0] CtlPatchDn  = 4'd7;
  localparam logic [3:0] CtlPatchUp  = 4'd8;
  localparam logic [3:0] CtlDigit    = 4'd9;

  // Message kinds
  localparam logic [2:0] MsgNoteOn  = 3'd0;
  localparam logic [2:0] MsgNoteOff = 3'd1;
  localparam logic [2:0] MsgCtrl    = 3'd2;
  localparam logic [2:0] MsgProgram = 3'd3;
  localparam logic [2:0] MsgMode    = 3'd4;

  // Digit entry modes
  localparam logic [1:0] ModePatch   = 2'd0;
  localparam logic [1:0] ModeBank    = 2'd1;
  localparam logic [1:0] ModeChannel = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CfgLowOct    = 2'd0;
  localparam logic [1:0] CfgHighOct   = 2'd1;
  localparam logic [1:0] CfgStartChan = 2'd2;

  // Fixed values
  localparam logic [6:0] DataMax      = 7'd127;
  localparam logic [3:0] ChanMax      = 4'd15;
  localparam logic [6:0] Velocity     = 7'd64;
  localparam logic [2:0] IdleLimit    = 3'd5;
  localparam logic [3:0] OctaveReset  = 4'd5;
  localparam logic [3:0] LowOctReset  = 4'd0;
  localparam logic [3:0] HighOctReset = 4'd9;
  localparam logic [3:0] StartChanRst = 4'd0;
  localparam logic [3:0] DigitMax     = 4'd9;

  // Result queue
  localparam int OutDepth = 8;
  localparam int OutPtrW  = 3;

endpackage

`default_nettype wire

// ----- design/key_matrix_to_midi_mapper.sv -----
// Key matrix to MIDI mapper: key map memory, control state, result queue.
// Depends on kmm_pkg.
//
// Usage:
// - Input channel (in_valid_i / in_stall_o / in_data_i) takes key events,
//   one-second ticks and key map writes, one beat per cycle while in_stall_o is low.
// - Output channel (out_valid_o / out_stall_i / out_data_o) gives MIDI
//   messages; one input makes zero, one or two beats, the last flagged by
//   last_of_run.
// - Config channel (cfg_valid_i / cfg_ready_o) always ready; write only
//   while the block is idle.
// - Path: an accepted input is registered in stage one, then queued as results.
// - Throughput: one input per cycle while each gives at most one beat and the
//   receiver does not stall; a run of two-beat inputs is throttled once the queue
//   fills. The key map is a single-port memory read once per accepted in-range
//   beat, and map writes go in at acceptance.
// - Reset: the key map is cleared by a sweep over all KEY_SLOTS entries, one entry
//   a cycle, with in_stall_o held high; config writes are taken meanwhile.
// - Receiver stall: results wait in an eight-deep queue; in_stall_o rises
//   once the queue might not hold the results of the items in flight.
`default_nettype none

module key_matrix_to_midi_mapper #(
  parameter int KEY_SLOTS = 1024
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire kmm_pkg::kmm_in_t in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output kmm_pkg::kmm_out_t    out_data_o,
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic [1:0]      cfg_index_i,
  input  wire logic [3:0]      cfg_data_i
);

  localparam int IdxW = $clog2(KEY_SLOTS);

  // Config registers
  logic [3:0] low_oct_q, high_oct_q;

  // Key map memory and clearing sweep
  logic [13:0]     key_mem [KEY_SLOTS];
  logic [13:0]     rdata_q;
  logic            clearing_q;
  logic [IdxW-1:0] clr_addr_q;

  // Stage one
  logic       s1_valid_q;
  logic [1:0] s1_func_q;
  logic [1:0] s1_kv_q;
  logic       s1_in_range_q;

  // Control state
  logic [3:0] oct_q, oct_d;
  logic [3:0] chan_q, chan_d;
  logic [6:0] patch_q, patch_d;
  logic [6:0] bank_q, bank_d;
  logic [1:0] mode_q, mode_d;
  logic [1:0] dcnt_q, dcnt_d;
  logic [9:0] dval_q, dval_d;
  logic [2:0] idle_q, idle_d;

  // Result queue
  kmm_pkg::kmm_out_t    fifo_q [kmm_pkg::OutDepth];
  logic [kmm_pkg::OutPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [kmm_pkg::OutPtrW:0]   cnt_q;

  logic              in_accept, pop;
  logic              key_in_range;
  logic [1:0]        res_n;
  kmm_pkg::kmm_out_t res0, res1;

  assign cfg_ready_o  = 1'b1;
  assign in_accept    = in_valid_i && !in_stall_o;
  assign pop          = out_valid_o && !out_stall_i;
  assign key_in_range = ({1'b0, in_data_i.key_code} < 11'(KEY_SLOTS));
  assign out_valid_o  = (cnt_q != '0);
  assign out_data_o   = fifo_q[rd_ptr_q];

  // Hold input while clearing or while the queue may overflow
  assign in_stall_o = clearing_q ||
    ((cnt_q + {{(kmm_pkg::OutPtrW-1){1'b0}}, s1_valid_q, 1'b0}) >
     (kmm_pkg::OutPtrW+1)'(kmm_pkg::OutDepth - 2));

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_oct_q  <= kmm_pkg::LowOctReset;
      high_oct_q <= kmm_pkg::HighOctReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        kmm_pkg::CfgLowOct:  low_oct_q  <= cfg_data_i;
        kmm_pkg::CfgHighOct: high_oct_q <= cfg_data_i;
        // start channel only matters at reset, where it is at its reset value
        default: ;
      endcase
    end
  end

  // Clearing sweep control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + IdxW'(1);
      if (clr_addr_q == IdxW'(KEY_SLOTS - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // Key map memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      key_mem[clr_addr_q] <= '0;
    end else if (in_accept && in_data_i.func == kmm_pkg::FuncMapWrite && key_in_range) begin
      key_mem[in_data_i.key_code[IdxW-1:0]] <= {in_data_i.entry_control,
                                                in_data_i.entry_kind,
                                                in_data_i.entry_number};
    end
    if (in_accept && key_in_range) begin
      rdata_q <= key_mem[in_data_i.key_code[IdxW-1:0]];
    end
  end

  // Advance stage one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_accept && (in_data_i.func == kmm_pkg::FuncKey ||
                                  in_data_i.func == kmm_pkg::FuncTick);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_func_q     <= in_data_i.func;
      s1_kv_q       <= in_data_i.key_value;
      s1_in_range_q <= key_in_range;
    end
  end

  // Decode the entry and update control state
  always_comb begin
    logic [13:0]       entry;
    logic [3:0]        ctl;
    logic [1:0]        kind;
    logic signed [7:0] num;
    logic              down;
    logic signed [9:0] note;
    logic [3:0]        digit;
    logic [1:0]        cnt0;
    logic [9:0]        dv0;
    logic [9:0]        dvn;
    logic [1:0]        cntn;
    logic [6:0]        val;

    entry = s1_in_range_q ? rdata_q : '0;
    ctl   = entry[13:10];
    kind  = entry[9:8];
    num   = signed'(entry[7:0]);
    down  = (s1_kv_q != kmm_pkg::KvRelease);
    note  = 10'(num) + 10'({oct_q, 3'b000}) + 10'({oct_q, 2'b00});
    digit = num[7] ? 4'd0 : ((num > 8'sd9) ? kmm_pkg::DigitMax : num[3:0]);
    cnt0  = (idle_q >= kmm_pkg::IdleLimit) ? 2'd0 : dcnt_q;
    dv0   = (cnt0 == 2'd0) ? 10'd0 : dval_q;
    dvn   = {dv0[6:0], 3'b000} + {dv0[8:0], 1'b0} + {6'd0, digit};
    cntn  = cnt0 + 2'd1;
    val   = (dvn > 10'd127) ? kmm_pkg::DataMax : dvn[6:0];

    oct_d   = oct_q;
    chan_d  = chan_q;
    patch_d = patch_q;
    bank_d  = bank_q;
    mode_d  = mode_q;
    dcnt_d  = dcnt_q;
    dval_d  = dval_q;
    idle_d  = idle_q;
    res_n   = 2'd0;
    res0    = '0;
    res1    = '0;
    res0.midi_channel = chan_q;
    res1.midi_channel = chan_q;

    if (s1_valid_q && s1_func_q == kmm_pkg::FuncTick) begin
      if (idle_q < kmm_pkg::IdleLimit) begin
        idle_d = idle_q + 3'd1;
      end
    end else if (s1_valid_q && s1_kv_q != kmm_pkg::KvRepeat) begin
      if (ctl != kmm_pkg::CtlNone) begin
        if (down) begin
          unique case (ctl)
            kmm_pkg::CtlMode: begin
              mode_d = (mode_q >= kmm_pkg::ModeChannel) ? kmm_pkg::ModePatch
                                                        : mode_q + 2'd1;
              res_n = 2'd1;
              res0.msg_kind   = kmm_pkg::MsgMode;
              res0.data_first = {5'd0, mode_d};
            end
            kmm_pkg::CtlOctDown: begin
              oct_d = (oct_q <= low_oct_q) ? low_oct_q : oct_q - 4'd1;
            end
            kmm_pkg::CtlOctUp: begin
              oct_d = (oct_q >= high_oct_q) ? high_oct_q : oct_q + 4'd1;
            end
            kmm_pkg::CtlChanDown: begin
              if (chan_q != 4'd0) chan_d = chan_q - 4'd1;
            end
            kmm_pkg::CtlChanUp: begin
              if (chan_q != kmm_pkg::ChanMax) chan_d = chan_q + 4'd1;
            end
            kmm_pkg::CtlPatchDn: begin
              if (patch_q == 7'd0 && bank_q != 7'd0) begin
                // borrow from the bank
                bank_d  = bank_q - 7'd1;
                patch_d = kmm_pkg::DataMax;
                res_n   = 2'd2;
                res0.msg_kind    = kmm_pkg::MsgCtrl;
                res0.data_second = bank_d;
                res1.msg_kind    = kmm_pkg::MsgProgram;
                res1.data_first  = patch_d;
              end else begin
                if (patch_q != 7'd0) patch_d = patch_q - 7'd1;
                res_n = 2'd1;
                res0.msg_kind   = kmm_pkg::MsgProgram;
                res0.data_first = patch_d;
              end
            end
            kmm_pkg::CtlPatchUp: begin
              if (patch_q == kmm_pkg::DataMax && bank_q != kmm_pkg::DataMax) begin
                // carry into the bank
                bank_d  = bank_q + 7'd1;
                patch_d = 7'd0;
                res_n   = 2'd2;
                res0.msg_kind    = kmm_pkg::MsgCtrl;
                res0.data_second = bank_d;
                res1.msg_kind    = kmm_pkg::MsgProgram;
                res1.data_first  = patch_d;
              end else begin
                if (patch_q != kmm_pkg::DataMax) patch_d = patch_q + 7'd1;
                res_n = 2'd1;
                res0.msg_kind   = kmm_pkg::MsgProgram;
                res0.data_first = patch_d;
              end
            end
            kmm_pkg::CtlDigit: begin
              idle_d = 3'd0;
              dval_d = dvn;
              dcnt_d = cntn;
              if (cntn == 2'd2 && mode_q == kmm_pkg::ModeChannel) begin
                chan_d = (dvn > 10'd15) ? kmm_pkg::ChanMax : dvn[3:0];
                dcnt_d = 2'd0;
              end else if (cntn == 2'd3) begin
                dcnt_d = 2'd0;
                if (mode_q == kmm_pkg::ModePatch) begin
                  patch_d = val;
                  res_n   = 2'd1;
                  res0.msg_kind   = kmm_pkg::MsgProgram;
                  res0.data_first = val;
                end else if (mode_q == kmm_pkg::ModeBank) begin
                  bank_d = val;
                  res_n  = 2'd1;
                  res0.msg_kind    = kmm_pkg::MsgCtrl;
                  res0.data_second = val;
                end
              end
            end
            default: ;
          endcase
        end
      end else if (kind == kmm_pkg::KindPedal) begin
        res_n = 2'd1;
        res0.msg_kind    = kmm_pkg::MsgCtrl;
        res0.data_first  = num[6:0];
        res0.data_second = down ? kmm_pkg::DataMax : 7'd0;
      end else if (kind == kmm_pkg::KindNote) begin
        res_n = 2'd1;
        res0.msg_kind    = down ? kmm_pkg::MsgNoteOn : kmm_pkg::MsgNoteOff;
        res0.data_second = kmm_pkg::Velocity;
        if (note < 10'sd0) begin
          res0.data_first = 7'd0;
        end else if (note > 10'sd127) begin
          res0.data_first = kmm_pkg::DataMax;
        end else begin
          res0.data_first = note[6:0];
        end
      end
    end

    // Flag the final beat of the run
    res0.last_of_run = (res_n == 2'd1);
    res1.last_of_run = (res_n == 2'd2);
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oct_q   <= kmm_pkg::OctaveReset;
      chan_q  <= kmm_pkg::StartChanRst;
      patch_q <= 7'd0;
      bank_q  <= 7'd0;
      mode_q  <= kmm_pkg::ModePatch;
      dcnt_q  <= 2'd0;
      dval_q  <= 10'd0;
      idle_q  <= kmm_pkg::IdleLimit;
    end else begin
      oct_q   <= oct_d;
      chan_q  <= chan_d;
      patch_q <= patch_d;
      bank_q  <= bank_d;
      mode_q  <= mode_d;
      dcnt_q  <= dcnt_d;
      dval_q  <= dval_d;
      idle_q  <= idle_d;
    end
  end

  // Result queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + kmm_pkg::OutPtrW'(res_n);
      if (pop) rd_ptr_q <= rd_ptr_q + kmm_pkg::OutPtrW'(1);
      cnt_q <= cnt_q + (kmm_pkg::OutPtrW+1)'(res_n) - (kmm_pkg::OutPtrW+1)'(pop);
    end
  end

  // Push results
  always_ff @(posedge clk_i) begin
    if (res_n != 2'd0) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (res_n == 2'd2) begin
      fifo_q[wr_ptr_q + kmm_pkg::OutPtrW'(1)] <= res1;
    end
  end

endmodule

`default_nettype wire

// ----- design/kmm_checker.sv -----
// Port-level checks for the key matrix to MIDI mapper, bound to the top.
// Depends on kmm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module kmm_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire kmm_pkg::kmm_out_t out_data_o
);

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result beat changed or dropped")
  `ASSERT_IMPLIES(a_kind_range, clk_i, rst_ni, out_valid_o, out_data_o.msg_kind <= kmm_pkg::MsgMode, "result kind out of range")
  `ASSERT_IMPLIES(a_note_velocity, clk_i, rst_ni, out_valid_o && (out_data_o.msg_kind == kmm_pkg::MsgNoteOn || out_data_o.msg_kind == kmm_pkg::MsgNoteOff), out_data_o.data_second == kmm_pkg::Velocity, "note beat without fixed velocity")
  `ASSERT_IMPLIES(a_mode_beat, clk_i, rst_ni, out_valid_o && out_data_o.msg_kind == kmm_pkg::MsgMode, out_data_o.data_second == 7'd0 && out_data_o.data_first <= 7'd2 && out_data_o.last_of_run, "bad mode indication")
  `ASSERT_IMPLIES(a_program_beat, clk_i, rst_ni, out_valid_o && out_data_o.msg_kind == kmm_pkg::MsgProgram, out_data_o.data_second == 7'd0 && out_data_o.last_of_run, "bad program change")

endmodule

bind key_matrix_to_midi_mapper kmm_checker u_kmm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for key_matrix_to_midi_mapper: key map writes, key
// events and ticks under sender gaps and receiver stalls, results scored beat by beat.
// Depends on kmm_pkg and the key_matrix_to_midi_mapper RTL.
`timescale 1ns / 1ps

module tb;
  import kmm_pkg::*;

  localparam int KeySlots       = 1024;
  localparam int SemisPerOctave = 12;
  localparam int QuietCycles    = 4;
  localparam int HoldCycles     = 80;
  localparam int PhaseCount     = 6;
  localparam int HoldPhase      = 4;
  localparam int HoldAt         = 40;
  localparam int RandomPerPhase = 230;
  localparam int TimeoutNs      = 2_000_000;

  // Codes the package leaves out
  localparam logic [1:0] FuncSpare   = 2'd3;
  localparam logic [1:0] KvPress     = 2'd1;
  localparam logic [1:0] KvPressAlt  = 2'd3;
  localparam logic [1:0] KindNone    = 2'd0;
  localparam logic [1:0] KindSpare   = 2'd3;
  localparam logic [3:0] CtlExit     = 4'd1;
  localparam logic [3:0] CtlUnused   = 4'd15;
  localparam logic [6:0] BankSelect  = 7'd0;
  localparam logic [1:0] DigitsFull  = 2'd3;
  localparam logic [1:0] DigitsChan  = 2'd2;

  // Key pool layout: notes, pedals, digits, one key per control role, then a noise key
  localparam int PedalStart = 8;
  localparam int DigitStart = 12;
  localparam int CtlStart   = 16;
  localparam int NoiseSlot  = 23;
  localparam int PoolSize   = 24;

  typedef struct packed {
    logic [3:0]        role;
    logic [1:0]        kind;
    logic signed [7:0] number;
  } map_entry_t;

  // Tracks mapper state, predicts MIDI messages and scores the output beats
  class midi_scoreboard;
    map_entry_t key_map [KeySlots];
    logic [3:0] octave, channel, low_oct, high_oct, start_chan;
    logic [6:0] patch, bank;
    logic [1:0] mode, digit_count;
    logic [9:0] digit_acc;
    logic [2:0] idle_secs;
    kmm_out_t   run_msgs[$];
    kmm_out_t   pending_msgs[$];
    int errors, n_keys, n_ticks, n_writes, n_other, n_msgs;

    function new();
      foreach (key_map[i]) key_map[i] = '0;
      octave      = OctaveReset;
      low_oct     = LowOctReset;
      high_oct    = HighOctReset;
      start_chan  = StartChanRst;
      channel     = StartChanRst;
      patch       = '0;
      bank        = '0;
      mode        = ModePatch;
      digit_count = '0;
      digit_acc   = '0;
      idle_secs   = IdleLimit;
      errors      = 0;
      n_keys      = 0;
      n_ticks     = 0;
      n_writes    = 0;
      n_other     = 0;
      n_msgs      = 0;
    endfunction

    function int pending_count();
      return pending_msgs.size();
    endfunction

    // Start channel only matters at reset, so hold it without touching channel
    function void write_reg(logic [1:0] idx, logic [3:0] val);
      case (idx)
        CfgLowOct:    low_oct = val;
        CfgHighOct:   high_oct = val;
        CfgStartChan: start_chan = val;
        default: ;
      endcase
    endfunction

    function void push_msg(logic [2:0] kind, logic [6:0] first, logic [6:0] second);
      kmm_out_t m;
      m.msg_kind     = kind;
      m.midi_channel = channel;
      m.data_first   = first;
      m.data_second  = second;
      m.last_of_run  = 1'b0;
      run_msgs.push_back(m);
    endfunction

    function void press_control(logic [3:0] role, int number);
      int digit;
      logic [6:0] value;
      case (role)
        CtlMode: begin
          mode = (mode == ModeChannel) ? ModePatch : mode + 2'd1;
          push_msg(MsgMode, {5'd0, mode}, 7'd0);
        end
        CtlOctDown: octave = (int'(octave) - 1 < int'(low_oct)) ? low_oct : octave - 4'd1;
        CtlOctUp:   octave = (int'(octave) + 1 > int'(high_oct)) ? high_oct : octave + 4'd1;
        CtlChanDown: if (channel != 4'd0) channel = channel - 4'd1;
        CtlChanUp:   if (channel < ChanMax) channel = channel + 4'd1;
        CtlPatchDn: begin
          // borrow from the bank when stepping below the first patch
          if (patch == 7'd0 && bank != 7'd0) begin
            bank  = bank - 7'd1;
            patch = DataMax;
            push_msg(MsgCtrl, BankSelect, bank);
          end else if (patch != 7'd0) begin
            patch = patch - 7'd1;
          end
          push_msg(MsgProgram, patch, 7'd0);
        end
        CtlPatchUp: begin
          // carry into the bank when stepping past the last patch
          if (patch == DataMax && bank < DataMax) begin
            bank  = bank + 7'd1;
            patch = 7'd0;
            push_msg(MsgCtrl, BankSelect, bank);
          end else if (patch < DataMax) begin
            patch = patch + 7'd1;
          end
          push_msg(MsgProgram, patch, 7'd0);
        end
        CtlDigit: begin
          digit = (number < 0) ? 0 : (number > int'(DigitMax)) ? int'(DigitMax) : number;
          // restart entry after an idle timeout
          if (idle_secs >= IdleLimit) digit_count = 2'd0;
          idle_secs = 3'd0;
          if (digit_count == 2'd0) digit_acc = 10'd0;
          digit_acc   = 10'(int'(digit_acc) * 10 + digit);
          digit_count = digit_count + 2'd1;
          if (digit_count == DigitsChan && mode == ModeChannel) begin
            channel     = (digit_acc > 10'(ChanMax)) ? ChanMax : digit_acc[3:0];
            digit_count = 2'd0;
          end else if (digit_count == DigitsFull) begin
            value = (digit_acc > 10'(DataMax)) ? DataMax : digit_acc[6:0];
            if (mode == ModePatch) begin
              patch = value;
              push_msg(MsgProgram, patch, 7'd0);
            end else if (mode == ModeBank) begin
              bank = value;
              push_msg(MsgCtrl, BankSelect, bank);
            end
            digit_count = 2'd0;
          end
        end
        default: ;
      endcase
    endfunction

    // Advance the state by one accepted input beat and queue its messages
    function void apply_input(kmm_in_t beat);
      map_entry_t entry;
      logic press;
      int number, note;
      kmm_out_t tail;
      run_msgs.delete();
      case (beat.func)
        FuncTick: begin
          n_ticks++;
          if (idle_secs < IdleLimit) idle_secs = idle_secs + 3'd1;
        end
        FuncMapWrite: begin
          n_writes++;
          key_map[beat.key_code] = {beat.entry_control, beat.entry_kind, beat.entry_number};
        end
        FuncKey: begin
          n_keys++;
          if (beat.key_value != KvRepeat) begin
            press  = (beat.key_value != KvRelease);
            entry  = key_map[beat.key_code];
            number = entry.number;
            if (entry.role != CtlNone) begin
              if (press) press_control(entry.role, number);
            end else if (entry.kind == KindPedal) begin
              push_msg(MsgCtrl, entry.number[6:0], press ? DataMax : 7'd0);
            end else if (entry.kind == KindNote) begin
              note = number + SemisPerOctave * int'(octave);
              if (note < 0) note = 0;
              if (note > int'(DataMax)) note = int'(DataMax);
              push_msg(press ? MsgNoteOn : MsgNoteOff, 7'(note), Velocity);
            end
          end
        end
        default: n_other++;
      endcase
      if (run_msgs.size() != 0) begin
        tail = run_msgs.pop_back();
        tail.last_of_run = 1'b1;
        run_msgs.push_back(tail);
        foreach (run_msgs[i]) pending_msgs.push_back(run_msgs[i]);
      end
    endfunction

    function void compare_field(string name, logic [6:0] want, logic [6:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_msg(kmm_out_t got);
      kmm_out_t want;
      n_msgs++;
      if (pending_msgs.size() == 0) begin
        $error("unexpected MIDI message: kind %0d channel %0d data %0d/%0d",
               got.msg_kind, got.midi_channel, got.data_first, got.data_second);
        errors++;
        return;
      end
      want = pending_msgs.pop_front();
      compare_field("msg_kind", 7'(want.msg_kind), 7'(got.msg_kind));
      compare_field("midi_channel", 7'(want.midi_channel), 7'(got.midi_channel));
      compare_field("data_first", want.data_first, got.data_first);
      compare_field("data_second", want.data_second, got.data_second);
      compare_field("last_of_run", 7'(want.last_of_run), 7'(got.last_of_run));
    endfunction
  endclass

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  kmm_in_t    in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  kmm_out_t   out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = CfgLowOct;
  logic [3:0] cfg_data  = '0;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_asked    = 0;
  int hold_taken    = 0;
  int hold_left     = 0;
  int cfg_sets      = 0;
  logic [9:0] map_pool [PoolSize];
  midi_scoreboard sb = new();

  key_matrix_to_midi_mapper #(
    .KEY_SLOTS(KeySlots)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Score every beat that crosses a channel at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.apply_input(in_data);
      if (out_valid && !out_stall) sb.check_msg(out_data);
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_asked) begin
      hold_taken <= hold_asked;
      hold_left  <= HoldCycles;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    #(TimeoutNs);
    $display("FAIL key_matrix_to_midi_mapper");
    $finish;
  end

  function automatic kmm_in_t map_write(logic [9:0] code, logic [3:0] role, logic [1:0] kind,
                                        logic [7:0] number);
    kmm_in_t beat;
    beat               = '0;
    beat.func          = FuncMapWrite;
    beat.key_code      = code;
    beat.entry_control = role;
    beat.entry_kind    = kind;
    beat.entry_number  = number;
    return beat;
  endfunction

  function automatic kmm_in_t key_event(logic [9:0] code, logic [1:0] kv);
    kmm_in_t beat;
    beat           = '0;
    beat.func      = FuncKey;
    beat.key_code  = code;
    beat.key_value = kv;
    return beat;
  endfunction

  // Map write that gives a pool key its role, with random content
  function automatic kmm_in_t pool_entry(int slot);
    kmm_in_t beat;
    logic [31:0] noise;
    noise              = $urandom;
    beat               = noise[$bits(kmm_in_t)-1:0];
    beat.func          = FuncMapWrite;
    beat.key_code      = map_pool[slot];
    beat.entry_control = CtlNone;
    if (slot < PedalStart) begin
      beat.entry_kind = KindNote;
      if ($urandom_range(1) == 0) beat.entry_number = 8'(int'($urandom_range(48)) - 24);
    end else if (slot < DigitStart) begin
      beat.entry_kind = KindPedal;
    end else if (slot < CtlStart) begin
      beat.entry_control = CtlDigit;
      if ($urandom_range(3) != 0) beat.entry_number = 8'($urandom_range(9));
    end else if (slot < NoiseSlot) begin
      // mode through patch up are consecutive role codes
      beat.entry_control = CtlMode + 4'(slot - CtlStart);
    end
    return beat;
  endfunction

  function automatic logic [1:0] random_kv();
    int r;
    r = $urandom_range(99);
    if (r < 45) return KvPress;
    if (r < 85) return KvRelease;
    if (r < 93) return KvRepeat;
    return KvPressAlt;
  endfunction

  // Mostly pool key presses and releases; else ticks, rewrites, control keys, noise
  function automatic kmm_in_t random_beat();
    kmm_in_t beat;
    logic [31:0] noise;
    int r;
    r     = $urandom_range(99);
    noise = $urandom;
    beat  = noise[$bits(kmm_in_t)-1:0];
    if (r < 55) begin
      beat.func      = FuncKey;
      beat.key_code  = map_pool[$urandom_range(PoolSize - 1)];
      beat.key_value = random_kv();
    end else if (r < 63) begin
      beat.func = FuncTick;
    end else if (r < 70) begin
      beat.func = FuncKey;
    end else if (r < 78) begin
      beat = pool_entry($urandom_range(PoolSize - 1));
    end else if (r < 84) begin
      beat.func = FuncMapWrite;
    end else if (r < 88) begin
      beat.func = FuncSpare;
    end else begin
      beat.func      = FuncKey;
      beat.key_code  = map_pool[$urandom_range(NoiseSlot - 1, DigitStart)];
      beat.key_value = KvPress;
    end
    return beat;
  endfunction

  // Offer one beat, hold it until taken, then idle at random
  task automatic send_beat(input kmm_in_t beat);
    int gap;
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain every expected message, then let in-flight silent beats settle
  task automatic wait_for_quiet();
    @(posedge clk);
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (QuietCycles) @(posedge clk);
  endtask

  task automatic program_regs(logic [3:0] low, logic [3:0] high, logic [3:0] chan);
    logic [1:0] idxs [3];
    logic [3:0] vals [3];
    idxs = '{CfgLowOct, CfgHighOct, CfgStartChan};
    vals = '{low, high, chan};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (cfg_ready !== 1'b1) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    cfg_sets++;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // hold off until the key map clearing sweep is done
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);

    // Directed: field extremes, clamps, pedal, controls and the patch carry
    send_beat(map_write(10'd0, CtlNone, KindNote, 8'h80));
    send_beat(map_write(10'd1023, CtlNone, KindNote, 8'h7f));
    send_beat(map_write(10'd1, CtlNone, KindPedal, 8'hff));
    send_beat(map_write(10'd2, CtlMode, KindNone, 8'd0));
    send_beat(map_write(10'd3, CtlDigit, KindNone, 8'd12));
    send_beat(map_write(10'd4, CtlPatchDn, KindNone, 8'd0));
    send_beat(map_write(10'd6, CtlPatchUp, KindNone, 8'd0));
    send_beat(map_write(10'd7, CtlExit, KindNote, 8'd5));
    send_beat(map_write(10'd8, CtlUnused, KindNote, 8'd0));
    send_beat(map_write(10'd9, CtlNone, KindSpare, 8'd5));
    send_beat(key_event(10'd0, KvPress));
    send_beat(key_event(10'd1023, KvPress));
    send_beat(key_event(10'd1, KvPressAlt));
    send_beat(key_event(10'd1, KvRepeat));
    send_beat(key_event(10'd4, KvPress));
    repeat (3) send_beat(key_event(10'd3, KvPress));
    send_beat(key_event(10'd6, KvPress));
    send_beat(key_event(10'd4, KvPress));
    send_beat(key_event(10'd2, KvPress));
    send_beat(key_event(10'd7, KvPress));
    send_beat(key_event(10'd8, KvPress));
    send_beat(key_event(10'd9, KvPress));
    send_beat(key_event(10'd4, KvRelease));
    in_valid <= 1'b0;

    // Random phases, each programming the registers and choosing an idle pattern
    for (int p = 0; p < PhaseCount; p++) begin
      wait_for_quiet();
      case (p)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
          program_regs(4'd0, 4'd9, ChanMax);
        end
        1: begin
          send_idle_pct = 71;
          stall_pct     = 0;
          program_regs(4'd0, 4'd0, 4'd0);
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 71;
          program_regs(4'd9, 4'd9, 4'($urandom_range(15)));
        end
        3: begin
          send_idle_pct = 11;
          stall_pct     = 11;
          program_regs(4'd3, 4'd6, 4'($urandom_range(15)));
        end
        4: begin
          send_idle_pct = 0;
          stall_pct     = 0;
          program_regs(4'($urandom_range(9)), 4'($urandom_range(9)), 4'($urandom_range(15)));
        end
        default: begin
          send_idle_pct = 71;
          stall_pct     = 71;
          program_regs(4'd0, 4'd9, 4'($urandom_range(15)));
        end
      endcase
      foreach (map_pool[i]) map_pool[i] = 10'($urandom_range(KeySlots - 1));
      for (int s = 0; s < PoolSize; s++) send_beat(pool_entry(s));
      for (int n = 0; n < RandomPerPhase; n++) begin
        if (p == HoldPhase && n == HoldAt) hold_asked++;
        send_beat(random_beat());
      end
      in_valid <= 1'b0;
    end

    wait_for_quiet();
    $display("Run covered %0d key events, %0d ticks, %0d map writes and %0d spare beats.",
             sb.n_keys, sb.n_ticks, sb.n_writes, sb.n_other);
    $display("Scored %0d MIDI messages over %0d register settings with gaps and stalls.",
             sb.n_msgs, cfg_sets);
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("PASS key_matrix_to_midi_mapper");
    end else begin
      $display("FAIL key_matrix_to_midi_mapper");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/kmm_pkg.sv
design/key_matrix_to_midi_mapper.sv
design/kmm_checker.sv
verif/tb.sv
